@@ design/pest_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the pendulum energy-shaping torque block.
package pest_pkg;

  localparam int AngleW  = 16;
  localparam int RateW   = 16;
  localparam int TorqueW = 32;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 8;
  localparam int CosW    = 18;

  localparam logic [CfgW-1:0] MassRst   = 16'd256;
  localparam logic [CfgW-1:0] LengthRst = 16'd128;
  localparam logic [CfgW-1:0] GravRst   = 16'd2511;
  localparam logic [CfgW-1:0] DampRst   = 16'd26;
  localparam logic [CfgW-1:0] GainRst   = 16'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMass   = 8'd0,
    CfgLength = 8'd1,
    CfgGrav   = 8'd2,
    CfgDamp   = 8'd3,
    CfgGain   = 8'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic signed [RateW-1:0]  angular_rate;
  } in_t;

  typedef struct packed {
    logic signed [TorqueW-1:0] torque;
    logic                      saturated;
  } out_t;

endpackage

@@ design/pendulum_energy_shaping_torque_top.sv @@
`timescale 1ns / 1ps
// Energy-shaping swing-up torque: seven-stage pipeline from state sample to torque.
// Throughput one item per cycle while the output is not stalled.
// Each stage advances when empty or when the stage after it moves, so bubbles collapse
// and a stalled output still lets the input fill empty stages.
// Reset clears all stage valid bits and loads the configuration registers with defaults.
module pendulum_energy_shaping_torque_top #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pest_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pest_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pest_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pest_pkg::CfgW-1:0]     cfg_data_i
);
  import pest_pkg::*;

  localparam int NStg = 7;
  localparam logic [31:0]        RecipTen = 32'hCCCC_CCCD;
  localparam logic signed [31:0] I32Max   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32Min   = -32'sh8000_0000;

  function automatic logic fits32(input logic signed [63:0] v);
    return (v <= 64'(I32Max)) && (v >= 64'(I32Min));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(I32Max)) begin
      r = I32Max;
    end else if (v < 64'(I32Min)) begin
      r = I32Min;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  logic [CfgW-1:0] mass_q, len_q, grav_q, damp_q, gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= MassRst;
      len_q  <= LengthRst;
      grav_q <= GravRst;
      damp_q <= DampRst;
      gain_q <= GainRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMass:   mass_q <= cfg_data_i;
        CfgLength: len_q  <= cfg_data_i;
        CfgGrav:   grav_q <= cfg_data_i;
        CfgDamp:   damp_q <= cfg_data_i;
        CfgGain:   gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NStg-1:0] en;
  logic [NStg-1:0] v_d, v_q;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NStg; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NStg-1];

  // stage 1: rate products, m*g
  logic signed [RateW-1:0] w;
  logic signed [16:0]      len_s, damp_s, gain_s;
  logic signed [32:0]      lw_d, dwf_d, gwr_d;
  logic [31:0]             mg_d;
  logic signed [32:0]      lw_q, dwf_q, gwr_q;
  logic [31:0]             mg_q;

  always_comb begin
    w      = in_data_i.angular_rate;
    len_s  = $signed({1'b0, len_q});
    damp_s = $signed({1'b0, damp_q});
    gain_s = $signed({1'b0, gain_q});
    lw_d   = len_s * w;
    dwf_d  = damp_s * w;
    gwr_d  = gain_s * w;
    mg_d   = mass_q * grav_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lw_q  <= lw_d;
      dwf_q <= dwf_d;
      gwr_q <= gwr_d;
      mg_q  <= mg_d;
    end
  end

  logic signed [CosW-1:0] cos_q;

  pest_cos_rom #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .ANGLE_BITS      (ANGLE_BITS)
  ) u_cos (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .angle_i (in_data_i.angle),
    .cos_o   (cos_q)
  );

  // stage 2: (l*w)^2, m*g*l, shifted rate terms
  logic [30:0]        lw_mag;
  logic [47:0]        mgl_full;
  logic [61:0]        sq_d, sq_q;
  logic [39:0]        mgl_d, mgl_q;
  logic signed [30:0] dw_d, dw2_q;
  logic signed [22:0] gw_d, gw2_q;

  always_comb begin
    lw_mag   = lw_q[32] ? 31'(-lw_q) : 31'(lw_q);
    sq_d     = lw_mag * lw_mag;
    mgl_full = mg_q * len_q;
    mgl_d    = mgl_full[47:8];
    dw_d     = 31'(dwf_q >>> 2);
    gw_d     = 23'(gwr_q >>> 10);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sq_q  <= sq_d;
      mgl_q <= mgl_d;
      dw2_q <= dw_d;
      gw2_q <= gw_d;
    end
  end

  // stage 3: kinetic, potential, mgl/10
  logic [57:0]        kin_full;
  logic signed [40:0] mgl_s;
  logic signed [58:0] pot_full;
  logic [63:0]        q10_full;
  logic [48:0]        kin_d, kin_q;
  logic signed [42:0] pot_d, pot_q;
  logic [28:0]        q10_d, q10_q;
  logic [30:0]        lo_q;
  logic               big_q;
  logic signed [30:0] dw3_q;
  logic signed [22:0] gw3_q;

  always_comb begin
    kin_full = sq_q[61:20] * mass_q;
    kin_d    = kin_full[57:9];
    mgl_s    = $signed({1'b0, mgl_q});
    pot_full = mgl_s * cos_q;
    pot_d    = pot_full[58:16];
    q10_full = {33'd0, mgl_q[30:0]} * {32'd0, RecipTen};
    q10_d    = q10_full[63:35];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      kin_q <= kin_d;
      pot_q <= pot_d;
      q10_q <= q10_d;
      lo_q  <= mgl_q[30:0];
      big_q <= |mgl_q[39:31];
      dw3_q <= dw2_q;
      gw3_q <= gw2_q;
    end
  end

  // stage 4: saturated Ed and E
  logic [31:0]        ed_sum;
  logic signed [50:0] e_full;
  logic signed [31:0] ed_d, ed_q, e_d, e_q;
  logic signed [30:0] dw4_q;
  logic signed [22:0] gw4_q;

  always_comb begin
    ed_sum = {1'b0, lo_q} + {3'd0, q10_q};
    ed_d   = (big_q || ed_sum[31]) ? I32Max : $signed(ed_sum);
    e_full = $signed({2'b00, kin_q}) - 51'(pot_q);
    e_d    = sat32(64'(e_full));
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ed_q  <= ed_d;
      e_q   <= e_d;
      dw4_q <= dw3_q;
      gw4_q <= gw3_q;
    end
  end

  // stage 5: energy error
  logic signed [32:0] diff_d, diff_q;
  logic signed [30:0] dw5_q;
  logic signed [22:0] gw5_q;

  assign diff_d = 33'(ed_q) - 33'(e_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      diff_q <= diff_d;
      dw5_q  <= dw4_q;
      gw5_q  <= gw4_q;
    end
  end

  // stage 6: gain * rate * error
  logic signed [55:0] shp_full;
  logic signed [39:0] shaped_d, shaped_q;
  logic signed [30:0] dw6_q;

  always_comb begin
    shp_full = gw5_q * diff_q;
    shaped_d = shp_full[55:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      shaped_q <= shaped_d;
      dw6_q    <= dw5_q;
    end
  end

  // stage 7: sum and clip
  logic signed [40:0] sum;
  out_t               out_d, out_q;

  always_comb begin
    sum             = 41'(dw6_q) + 41'(shaped_q);
    out_d.torque    = sat32(64'(sum));
    out_d.saturated = !fits32(64'(sum));
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ design/pest_cos_rom.sv @@
`timescale 1ns / 1ps
// Quarter-wave cosine lookup: index stage, then registered table read with sign fixup.
module pest_cos_rom #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic [1:0]                          en_i,
  input  logic signed [pest_pkg::AngleW-1:0]  angle_i,
  output logic signed [pest_pkg::CosW-1:0]    cos_o
);
  import pest_pkg::*;

  localparam int Q  = ANGLE_BITS - 2;
  localparam int IW = $clog2(COS_TABLE_DEPTH);
  localparam int DW = $clog2(COS_TABLE_DEPTH + 1);
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef logic [16:0] rom_t [COS_TABLE_DEPTH];

  function automatic rom_t build_table();
    rom_t              t;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            c;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      x    = (HalfPiQ30 * 64'(k)) / COS_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      c    = 64'sd1 << 30;
      term = ((term * x2) >> 30) / 2;   c = c - longint'(term);
      term = ((term * x2) >> 30) / 12;  c = c + longint'(term);
      term = ((term * x2) >> 30) / 30;  c = c - longint'(term);
      term = ((term * x2) >> 30) / 56;  c = c + longint'(term);
      term = ((term * x2) >> 30) / 90;  c = c - longint'(term);
      term = ((term * x2) >> 30) / 132; c = c + longint'(term);
      term = ((term * x2) >> 30) / 182; c = c - longint'(term);
      term = ((term * x2) >> 30) / 240; c = c + longint'(term);
      term = ((term * x2) >> 30) / 306; c = c - longint'(term);
      term = ((term * x2) >> 30) / 380; c = c + longint'(term);
      term = ((term * x2) >> 30) / 462; c = c - longint'(term);
      term = ((term * x2) >> 30) / 552; c = c + longint'(term);
      t[k] = (c > 0) ? 17'((c + 64'sd8192) >>> 14) : 17'd0;
    end
    return t;
  endfunction

  localparam rom_t CosTable = build_table();

  logic signed [ANGLE_BITS-1:0] a_wrap;
  logic [Q-1:0]                 pos;
  logic [1:0]                   quad;
  logic [Q+DW-1:0]              scaled;
  logic [IW-1:0]                idx;
  logic [IW:0]                  mirror_idx;
  logic [IW-1:0]                idx_d;
  logic                         neg_d;
  logic                         zero_d;

  logic [IW-1:0]                idx_q;
  logic                         neg_q;
  logic                         zero_q;
  logic [16:0]                  mag;
  logic signed [CosW-1:0]       cos_d;
  logic signed [CosW-1:0]       cos_q;

  always_comb begin
    a_wrap     = ANGLE_BITS'(angle_i);
    quad       = a_wrap[ANGLE_BITS-1:ANGLE_BITS-2];
    pos        = a_wrap[Q-1:0];
    scaled     = (Q+DW)'(pos) * (Q+DW)'(COS_TABLE_DEPTH);
    idx        = scaled[Q+IW-1:Q];
    mirror_idx = (IW+1)'(COS_TABLE_DEPTH) - {1'b0, idx};
    idx_d      = quad[0] ? mirror_idx[IW-1:0] : idx;
    zero_d     = quad[0] && (idx == '0);
    neg_d      = quad[1] ^ quad[0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      idx_q  <= idx_d;
      neg_q  <= neg_d;
      zero_q <= zero_d;
    end
  end

  always_comb begin
    mag   = zero_q ? 17'd0 : CosTable[idx_q];
    cos_d = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cos_q <= cos_d;
    end
  end

  assign cos_o = cos_q;

endmodule

@@ dv/tb_pendulum_energy_shaping_torque_top.sv @@
`timescale 1ns / 1ps
// Testbench for the energy-shaping swing-up torque block: directed and random samples checked against a predictor.
module tb_pendulum_energy_shaping_torque_top;
  import pest_pkg::*;

  localparam int CosDepth = 1024;
  localparam int AngleBits = 16;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam int MaxCycles = 400000;
  localparam int NumDirected = 20;
  localparam int MaxReported = 10;

  class torque_scoreboard;
    int rom[CosDepth];
    longint unsigned mass, arm_len, grav, damp_k, gain;
    out_t expected_q[$];
    int mismatches;

    function new();
      longint unsigned x, x2, term;
      longint c;
      mass = MassRst;
      arm_len = LengthRst;
      grav = GravRst;
      damp_k = DampRst;
      gain = GainRst;
      mismatches = 0;
      for (int k = 0; k < CosDepth; k++) begin
        x = HalfPiQ30 * 64'(k) / 64'(CosDepth);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        c = longint'(term);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) c -= longint'(term);
          else c += longint'(term);
        end
        rom[k] = (c > 0) ? int'((c + 64'sd8192) >>> 14) : 0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
      case (idx)
        CfgMass:   mass = v;
        CfgLength: arm_len = v;
        CfgGrav:   grav = v;
        CfgDamp:   damp_k = v;
        CfgGain:   gain = v;
        default: ;
      endcase
    endfunction

    function longint rom_at(longint unsigned i);
      return (i < CosDepth) ? longint'(rom[i]) : 0;
    endfunction

    function longint clip32(longint v, inout bit clipped);
      if (v > 64'sd2147483647) begin
        clipped = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clipped = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function out_t torque_for(in_t s);
      longint unsigned a, quad, pos, idx, mgl, lw_mag, kin;
      longint w, c, lw, ed, pot, e_tot, damp, gw, shaped, tau;
      bit dummy, clipped;
      out_t r;
      a = 64'(longint'(s.angle)) & ((64'd1 << AngleBits) - 1);
      quad = (a >> (AngleBits - 2)) & 64'd3;
      pos = a & ((64'd1 << (AngleBits - 2)) - 1);
      idx = (pos * CosDepth) >> (AngleBits - 2);
      case (quad)
        0: c = rom_at(idx);
        1: c = -rom_at(CosDepth - idx);
        2: c = -rom_at(idx);
        default: c = rom_at(CosDepth - idx);
      endcase
      w = longint'(s.angular_rate);
      mgl = (mass * grav * arm_len) >> 8;
      lw = longint'(arm_len) * w;
      lw_mag = 64'((lw < 0) ? -lw : lw);
      kin = (((lw_mag * lw_mag) >> 20) * mass) >> 9;
      dummy = 1'b0;
      clipped = 1'b0;
      ed = clip32(longint'(mgl * 64'd11 / 64'd10), dummy);
      pot = (longint'(mgl) * c) >>> 16;
      e_tot = clip32(longint'(kin) - pot, dummy);
      damp = (longint'(damp_k) * w) >>> 2;
      gw = (longint'(gain) * w) >>> 10;
      shaped = (gw * (ed - e_tot)) >>> 16;
      tau = clip32(damp + shaped, clipped);
      r.torque = tau[31:0];
      r.saturated = clipped;
      return r;
    endfunction

    function void note_sample(in_t s);
      expected_q.push_back(torque_for(s));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      if (mismatches < MaxReported) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result torque=%0d sat=%0b", got.torque, got.saturated));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.torque !== exp_r.torque)
        report($sformatf("torque expected %0d actual %0d", exp_r.torque, got.torque));
      if (got.saturated !== exp_r.saturated)
        report($sformatf("saturated expected %0b actual %0b", exp_r.saturated, got.saturated));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  torque_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;

  logic [15:0] dir_angle[NumDirected] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001,
    16'hFFFF, 16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h0010, 16'h2000, 16'hE000,
    16'h000F, 16'h5555, 16'hAAAA, 16'h7FF0};
  logic [15:0] dir_rate[NumDirected] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0400, 16'h7FFF, 16'h8000,
    16'hFC00, 16'h0200, 16'hFE00, 16'h0064, 16'hFF9C, 16'h7FFF, 16'h8000, 16'h0800,
    16'hF800, 16'h0007, 16'hFFF9, 16'h0001};

  pendulum_energy_shaping_torque_top #(
    .COS_TABLE_DEPTH(CosDepth),
    .ANGLE_BITS(AngleBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == MaxCycles) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_pendulum_energy_shaping_torque_top: FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_sample(in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [CfgW-1:0] m, logic [CfgW-1:0] l, logic [CfgW-1:0] g,
                           logic [CfgW-1:0] d, logic [CfgW-1:0] k);
    write_reg(CfgMass, m);
    write_reg(CfgLength, l);
    write_reg(CfgGrav, g);
    write_reg(CfgDamp, d);
    write_reg(CfgGain, k);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_reg_value();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CfgW'($urandom);
    endcase
  endfunction

  task automatic run_items(int n_items, int mode, bit directed);
    in_t s;
    send_idle_pct = (mode == 1) ? 81 : (mode == 3) ? 26 : 0;
    stall_pct = (mode == 2) ? 81 : (mode == 3) ? 26 : 0;
    if (directed) begin
      for (int i = 0; i < NumDirected; i++) begin
        s.angle = dir_angle[i];
        s.angular_rate = dir_rate[i];
        send_sample(s);
      end
    end
    for (int i = 0; i < n_items; i++) begin
      s.angle = AngleW'($urandom);
      if ($urandom_range(1) == 0) s.angular_rate = RateW'($urandom);
      else s.angular_rate = RateW'(int'($urandom_range(8191)) - 4096);
      send_sample(s);
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_items(100, 0, 1'b1);
    configure('1, '1, '1, '1, '1);
    run_items(120, 1, 1'b1);
    configure('0, '0, '0, '0, '0);
    run_items(100, 2, 1'b0);
    configure(MassRst, LengthRst, GravRst, DampRst, GainRst);
    // out-of-range index must leave every register alone
    write_reg(CfgIdxW'($urandom_range(255, int'(CfgGain) + 1)), CfgW'($urandom));
    cfg_valid_i = 1'b0;
    run_items(120, 3, 1'b0);
    for (int p = 0; p < 8; p++) begin
      configure(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value(),
                pick_reg_value());
      run_items(85, p % 4, 1'b0);
    end

    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_pendulum_energy_shaping_torque_top: PASS");
    end else begin
      $display("tb_pendulum_energy_shaping_torque_top: FAIL");
    end
    $finish;
  end

endmodule
